// File: hdl/gap_buffer_cursor_engine_assert.svh
// Assertion macros used by the gap buffer cursor engine control module.
`ifndef GAP_BUFFER_CURSOR_ENGINE_ASSERT_SVH
`define GAP_BUFFER_CURSOR_ENGINE_ASSERT_SVH

// The property must hold in the same cycle as the trigger.
`define GBCE_ASSERT_NOW(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error("gap buffer assertion failed");

// The property must hold in the cycle after the trigger.
`define GBCE_ASSERT_NEXT(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("gap buffer assertion failed");

`endif

// File: hdl/gbce_pkg.sv
// Types, constants and helper functions of the gap buffer cursor engine.
package gbce_pkg;

    localparam int LINE_W = 13;
    localparam int COL_W  = 8;
    localparam int SYM_W  = 8;
    localparam int STEP_W = 13;

    localparam logic [SYM_W-1:0] LINE_FEED   = 8'h0A;
    localparam logic [COL_W-1:0] RESET_WIDTH = 8'd80;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_LEFT,
        OP_RIGHT
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_MOVE_L_WR,
        S_MOVE_R_WR,
        S_BACK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_OUT
    } state_t;

    // Cursor update requests from the sequencer.
    typedef struct packed {
        logic             fwd;
        logic             fwd_lf;
        logic             back;
        logic             scan_done;
        logic [COL_W-1:0] scan_col;
    } cur_cmd_t;

    // Counts up modulo the line width; a width of zero acts as 256.
    function automatic logic [COL_W-1:0] wrap_inc(input logic [COL_W-1:0] v,
                                                  input logic [COL_W-1:0] w);
        logic [COL_W-1:0] last;
        last = w - COL_W'(1);
        return (v == last) ? '0 : v + COL_W'(1);
    endfunction

endpackage

// File: hdl/gbce_if.sv
// Request and response channel interfaces of the gap buffer cursor engine.
interface gbce_req_if;
    logic                          valid;
    logic                          ready;
    gbce_pkg::op_t                 op;
    logic [gbce_pkg::SYM_W-1:0]    symbol;
    logic [gbce_pkg::STEP_W-1:0]   steps;

    modport source (output valid, output op, output symbol, output steps, input ready);
    modport sink (input valid, input op, input symbol, input steps, output ready);
endinterface

interface gbce_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [gbce_pkg::LINE_W-1:0]   line_index;
    logic [gbce_pkg::COL_W-1:0]    column_index;
    logic                          at_end;
    logic                          rejected;

    modport source (output valid, output line_index, output column_index,
                    output at_end, output rejected, input ready);
    modport sink (input valid, input line_index, input column_index,
                  input at_end, input rejected, output ready);
endinterface

// File: hdl/gbce_ram.sv
// Generic single write port, single registered read port RAM.
module gbce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// File: hdl/gbce_cursor.sv
// Cursor line and column tracking with the line width register.
module gbce_cursor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [gbce_pkg::COL_W-1:0]  wr_data,
    input  gbce_pkg::cur_cmd_t          cmd,
    output logic [gbce_pkg::LINE_W-1:0] line,
    output logic [gbce_pkg::COL_W-1:0]  col,
    output logic [gbce_pkg::COL_W-1:0]  width,
    output logic                        need_scan
);
    import gbce_pkg::*;

    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg  <= '0;
            col_reg   <= '0;
            width_reg <= RESET_WIDTH;
        end
        else
        begin
            line_reg <= line_next;
            col_reg  <= col_next;
            if (wr_en)
            begin
                width_reg <= wr_data;
            end
        end
    end

    always_comb
    begin
        line_next = line_reg;
        col_next  = col_reg;
        if (cmd.fwd)
        begin
            // A line feed or the last column wraps onto the next line.
            if (cmd.fwd_lf || (col_reg == width_reg - COL_W'(1)))
            begin
                col_next  = '0;
                line_next = line_reg + LINE_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        else if (cmd.scan_done)
        begin
            col_next  = cmd.scan_col;
            line_next = line_reg - LINE_W'(1);
        end
        else if (cmd.back && (col_reg != '0))
        begin
            col_next = col_reg - COL_W'(1);
        end
    end

    assign line      = line_reg;
    assign col       = col_reg;
    assign width     = width_reg;
    assign need_scan = (col_reg == '0) && (line_reg != '0);
endmodule

// File: hdl/gbce_ctrl.sv
// Sequencer, gap pointers and text store of the gap buffer cursor engine.
`include "gap_buffer_cursor_engine_assert.svh"

module gbce_ctrl #(
    parameter int CAPACITY = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    gbce_req_if.sink                    req,
    gbce_rsp_if.source                  rsp,
    input  logic [gbce_pkg::LINE_W-1:0] line,
    input  logic [gbce_pkg::COL_W-1:0]  col,
    input  logic [gbce_pkg::COL_W-1:0]  width,
    input  logic                        need_scan,
    output gbce_pkg::cur_cmd_t          cmd
);
    import gbce_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] CAP = PW'(CAPACITY);

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [STEP_W-1:0] rem_reg, rem_next;
    logic [PW-1:0]     gs_reg, gs_next;
    logic [PW-1:0]     ge_reg, ge_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [COL_W-1:0]  cnt_reg, cnt_next;
    logic              rej_reg, rej_next;

    logic [PW-1:0]     gs_dec, ge_dec, pos_dec;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [SYM_W-1:0]  ram_wdata, ram_rdata;
    state_t            after_back;

    assign gs_dec  = gs_reg - PW'(1);
    assign ge_dec  = ge_reg - PW'(1);
    assign pos_dec = pos_reg - PW'(1);
    // A move left resumes its step loop after each backward step.
    assign after_back = (op_reg == OP_LEFT) ? S_OP : S_OUT;

    gbce_ram #(
        .WIDTH(SYM_W),
        .DEPTH(CAPACITY)
    ) u_text (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gs_reg    <= '0;
            ge_reg    <= CAP;
            rej_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gs_reg    <= gs_next;
            ge_reg    <= ge_next;
            rej_reg   <= rej_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        sym_reg <= sym_next;
        rem_reg <= rem_next;
        pos_reg <= pos_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_OP;
                end
            end
            S_OP:
            begin
                case (op_reg)
                    OP_INSERT: state_next = S_OUT;
                    OP_DELETE: state_next = (gs_reg == '0) ? S_OUT : S_BACK;
                    OP_LEFT:
                        state_next = ((rem_reg == '0) || (gs_reg == '0)) ? S_OUT : S_MOVE_L_WR;
                    OP_RIGHT:
                        state_next = ((rem_reg == '0) || (ge_reg == CAP)) ? S_OUT : S_MOVE_R_WR;
                    default: state_next = S_OUT;
                endcase
            end
            S_MOVE_L_WR: state_next = S_BACK;
            S_MOVE_R_WR: state_next = S_OP;
            S_BACK:      state_next = need_scan ? S_SCAN_RD : after_back;
            S_SCAN_RD:   state_next = (pos_reg == '0) ? after_back : S_SCAN_CHK;
            S_SCAN_CHK:  state_next = (ram_rdata == LINE_FEED) ? after_back : S_SCAN_RD;
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next   = op_reg;
        sym_next  = sym_reg;
        rem_next  = rem_reg;
        gs_next   = gs_reg;
        ge_next   = ge_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        rej_next  = rej_reg;
        ram_we    = 1'b0;
        ram_waddr = gs_reg[AW-1:0];
        ram_wdata = sym_reg;
        ram_raddr = gs_dec[AW-1:0];
        cmd       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next  = req.op;
                    sym_next = req.symbol;
                    rem_next = req.steps;
                    rej_next = 1'b0;
                end
            end
            S_OP:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (gs_reg == ge_reg)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            gs_next    = gs_reg + PW'(1);
                            cmd.fwd    = 1'b1;
                            cmd.fwd_lf = (sym_reg == LINE_FEED);
                        end
                    end
                    OP_DELETE:
                    begin
                        if (gs_reg == '0)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            gs_next = gs_dec;
                        end
                    end
                    OP_LEFT:  ram_raddr = gs_dec[AW-1:0];
                    OP_RIGHT: ram_raddr = ge_reg[AW-1:0];
                    default:  rej_next = rej_reg;
                endcase
            end
            S_MOVE_L_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ge_dec[AW-1:0];
                ram_wdata = ram_rdata;
                gs_next   = gs_dec;
                ge_next   = ge_dec;
                rem_next  = rem_reg - STEP_W'(1);
            end
            S_MOVE_R_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = gs_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                gs_next    = gs_reg + PW'(1);
                ge_next    = ge_reg + PW'(1);
                rem_next   = rem_reg - STEP_W'(1);
                cmd.fwd    = 1'b1;
                cmd.fwd_lf = (ram_rdata == LINE_FEED);
            end
            S_BACK:
            begin
                if (need_scan)
                begin
                    pos_next = gs_reg;
                    cnt_next = '0;
                end
                else
                begin
                    cmd.back = 1'b1;
                end
            end
            S_SCAN_RD:
            begin
                ram_raddr = pos_dec[AW-1:0];
                if (pos_reg == '0)
                begin
                    cmd.scan_done = 1'b1;
                    cmd.scan_col  = cnt_reg;
                end
            end
            S_SCAN_CHK:
            begin
                if (ram_rdata == LINE_FEED)
                begin
                    cmd.scan_done = 1'b1;
                    cmd.scan_col  = cnt_reg;
                end
                else
                begin
                    pos_next = pos_dec;
                    cnt_next = wrap_inc(cnt_reg, width);
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = (state_reg == S_OUT);
    assign rsp.line_index   = line;
    assign rsp.column_index = col;
    assign rsp.at_end       = (ge_reg == CAP);
    assign rsp.rejected     = rej_reg;

    `GBCE_ASSERT_NOW(a_gap_order, 1'b1, (gs_reg <= ge_reg) && (ge_reg <= CAP))
    `GBCE_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
    `GBCE_ASSERT_NOW(a_reject_edit_only, rsp.valid && rsp.rejected,
        (op_reg == OP_INSERT) || (op_reg == OP_DELETE))
    `GBCE_ASSERT_NOW(a_single_cursor_cmd, 1'b1,
        $countones({cmd.fwd, cmd.back, cmd.scan_done}) <= 1)
endmodule

// File: hdl/gap_buffer_cursor_engine.sv
// Gap buffer cursor engine: the text editing block with cursor line and column.
// Usage:
//   req carries one edit item: op (insert, delete, move left, move right),
//   symbol for inserts and steps for moves. rsp returns one item per request
//   with the cursor line, column, at_end and rejected flags.
//   wr_en and wr_data set the line width; write it only while the block is idle.
// Timing:
//   The block takes one item at a time; req.ready is high only when idle.
//   An insert or a rejected edit goes from S_OP to S_OUT, which raises
//   rsp.valid; a delete without a scan passes S_BACK on the way.
//   A move reads and then writes each byte crossed through the single text
//   memory port, plus a backward step (S_BACK) each byte when moving left.
//   A backward step from column zero scans to the previous line feed with
//   one registered memory read per byte scanned, in S_SCAN_RD then S_SCAN_CHK.
// Reset:
//   rst_n clears the buffer to empty, the cursor to line 0 column 0 and the
//   width to 80. No memory clearing is needed.
// Stalls:
//   A result waits on rsp with valid held until rsp.ready; no new item is
//   taken before then.
module gap_buffer_cursor_engine #(
    parameter int CAPACITY = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [gbce_pkg::COL_W-1:0] wr_data,
    gbce_req_if.sink                   req,
    gbce_rsp_if.source                 rsp
);
    import gbce_pkg::*;

    cur_cmd_t          cmd;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  width;
    logic              need_scan;

    gbce_cursor u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_data   (wr_data),
        .cmd       (cmd),
        .line      (line),
        .col       (col),
        .width     (width),
        .need_scan (need_scan)
    );

    gbce_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .line      (line),
        .col       (col),
        .width     (width),
        .need_scan (need_scan),
        .cmd       (cmd)
    );
endmodule

// File: sim/gbce_cursor_checker.sv
// Checker that predicts the cursor of the gap buffer engine and compares every result item.
`timescale 1ns / 1ps

module gbce_cursor_checker #(
    parameter int CAPACITY = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [gbce_pkg::COL_W-1:0] wr_data,
    gbce_req_if                        req,
    gbce_rsp_if                        rsp,
    output int                         pending,
    output int                         text_len,
    output int                         errors
);
    import gbce_pkg::*;

    typedef struct packed {
        logic [LINE_W-1:0] line_index;
        logic [COL_W-1:0]  column_index;
        logic              at_end;
        logic              rejected;
    } cursor_result_t;

    logic [SYM_W-1:0]  text_mem [CAPACITY];
    int                gap_lo;
    int                gap_hi;
    logic [LINE_W-1:0] cur_line;
    logic [COL_W-1:0]  cur_col;
    logic [COL_W-1:0]  width;
    cursor_result_t    cursor_q[$];

    assign text_len = gap_lo + CAPACITY - gap_hi;

    // A width of zero counts as 256 columns.
    function automatic int cols_per_line();
        return (width == '0) ? 256 : int'(width);
    endfunction

    function automatic void advance_cursor();
        if (text_mem[gap_lo - 1] == LINE_FEED || int'(cur_col) == cols_per_line() - 1)
        begin
            cur_col  = '0;
            cur_line = cur_line + LINE_W'(1);
        end
        else
        begin
            cur_col = cur_col + COL_W'(1);
        end
    endfunction

    function automatic void retreat_cursor();
        int pos;
        int count;
        if (cur_col == '0 && cur_line != '0)
        begin
            pos   = gap_lo;
            count = 0;
            while (pos > 0 && text_mem[pos - 1] != LINE_FEED)
            begin
                pos--;
                count++;
            end
            cur_col  = COL_W'(count % cols_per_line());
            cur_line = cur_line - LINE_W'(1);
        end
        else if (cur_col != '0)
        begin
            cur_col = cur_col - COL_W'(1);
        end
    endfunction

    function automatic cursor_result_t apply_edit(op_t op, logic [SYM_W-1:0] symbol,
                                                  logic [STEP_W-1:0] steps);
        cursor_result_t res;
        res.rejected = 1'b0;
        case (op)
            OP_INSERT:
            begin
                if (gap_lo == gap_hi)
                begin
                    res.rejected = 1'b1;
                end
                else
                begin
                    text_mem[gap_lo] = symbol;
                    gap_lo++;
                    advance_cursor();
                end
            end
            OP_DELETE:
            begin
                if (gap_lo == 0)
                begin
                    res.rejected = 1'b1;
                end
                else
                begin
                    gap_lo--;
                    retreat_cursor();
                end
            end
            OP_LEFT:
            begin
                for (int k = 0; k < int'(steps) && gap_lo > 0; k++)
                begin
                    gap_lo--;
                    gap_hi--;
                    text_mem[gap_hi] = text_mem[gap_lo];
                    retreat_cursor();
                end
            end
            default:
            begin
                for (int k = 0; k < int'(steps) && gap_hi < CAPACITY; k++)
                begin
                    text_mem[gap_lo] = text_mem[gap_hi];
                    gap_lo++;
                    gap_hi++;
                    advance_cursor();
                end
            end
        endcase
        res.line_index   = cur_line;
        res.column_index = cur_col;
        res.at_end       = (gap_hi == CAPACITY);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cursor_result_t want;
        cursor_result_t got;
        if (!rst_n)
        begin
            gap_lo   = 0;
            gap_hi   = CAPACITY;
            cur_line = '0;
            cur_col  = '0;
            width    = RESET_WIDTH;
            errors   = 0;
            cursor_q.delete();
            pending  = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.line_index, rsp.column_index, rsp.at_end, rsp.rejected};
                if (cursor_q.size() == 0)
                begin
                    $display("%0t: unexpected result item, actual %p", $realtime, got);
                    errors++;
                end
                else
                begin
                    want = cursor_q.pop_front();
                    if (got.line_index !== want.line_index)
                    begin
                        $display("%0t: line_index expected %0d actual %0d",
                                 $realtime, want.line_index, got.line_index);
                        errors++;
                    end
                    if (got.column_index !== want.column_index)
                    begin
                        $display("%0t: column_index expected %0d actual %0d",
                                 $realtime, want.column_index, got.column_index);
                        errors++;
                    end
                    if (got.at_end !== want.at_end)
                    begin
                        $display("%0t: at_end expected %0b actual %0b",
                                 $realtime, want.at_end, got.at_end);
                        errors++;
                    end
                    if (got.rejected !== want.rejected)
                    begin
                        $display("%0t: rejected expected %0b actual %0b",
                                 $realtime, want.rejected, got.rejected);
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                cursor_q.push_back(apply_edit(req.op, req.symbol, req.steps));
            end
            if (wr_en)
            begin
                width = wr_data;
            end
            pending = cursor_q.size();
        end
    end

endmodule

// File: sim/tb_gap_buffer_cursor_engine.sv
// Testbench top of the gap buffer cursor engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_gap_buffer_cursor_engine;
    import gbce_pkg::*;

    localparam int CAPACITY = 4096;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             wr_en = 1'b0;
    logic [COL_W-1:0] wr_data = '0;
    int               pending;
    int               text_len;
    int               errors;
    int               burst_left = 0;
    int               hold_left = 0;
    bit               hold_req = 1'b0;
    int               stall_pct = 0;
    int               rx_cycle = 0;

    gbce_req_if req_ch ();
    gbce_rsp_if rsp_ch ();

    gap_buffer_cursor_engine #(.CAPACITY(CAPACITY)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    gbce_cursor_checker #(.CAPACITY(CAPACITY)) i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (wr_data),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .pending  (pending),
        .text_len (text_len),
        .errors   (errors)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // The receiver stalls at a rate it redraws among 0, 30 and 60 percent, and can hold off on request.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 300;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (rx_cycle % 64 == 0)
                    stall_pct = 30 * $urandom_range(0, 2);
                rsp_ch.ready <= ($urandom_range(1, 100) > stall_pct);
            end
        end
    end

    task automatic send_edit(op_t op, logic [SYM_W-1:0] symbol, logic [STEP_W-1:0] steps);
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_ch.valid  <= 1'b1;
        req_ch.op     <= op;
        req_ch.symbol <= symbol;
        req_ch.steps  <= steps;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_width(logic [COL_W-1:0] w);
        drain();
        wr_en   <= 1'b1;
        wr_data <= w;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Random edits on a short text so that backward scans stay cheap.
    task automatic random_edits(int count);
        op_t              op;
        logic [SYM_W-1:0] symbol;
        logic [STEP_W-1:0] steps;
        for (int i = 0; i < count; i++)
        begin
            op     = op_t'($urandom_range(0, 3));
            symbol = ($urandom_range(0, 5) == 0) ? LINE_FEED : SYM_W'($urandom);
            steps  = ($urandom_range(0, 19) == 0) ? STEP_W'($urandom_range(0, 4096))
                                                  : STEP_W'($urandom_range(0, 12));
            if (op == OP_INSERT && text_len >= 96)
                op = OP_DELETE;
            if ($urandom_range(0, 3) == 0 && op != OP_LEFT && op != OP_RIGHT)
                op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_DELETE;
            send_edit(op, symbol, steps);
        end
    endtask

    initial
    begin
        req_ch.valid  = 1'b0;
        req_ch.op     = OP_INSERT;
        req_ch.symbol = '0;
        req_ch.steps  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Edges of an empty buffer, then bytes of every kind.
        send_edit(OP_DELETE, 8'h00, 13'd0);
        send_edit(OP_LEFT, 8'h00, 13'd4096);
        send_edit(OP_RIGHT, 8'h00, 13'd4096);
        send_edit(OP_INSERT, 8'h00, 13'd8191);
        send_edit(OP_INSERT, 8'hFF, 13'd0);
        send_edit(OP_INSERT, LINE_FEED, 13'd0);
        send_edit(OP_INSERT, 8'h41, 13'd0);
        send_edit(OP_LEFT, 8'h00, 13'd0);
        send_edit(OP_LEFT, 8'h00, 13'd2);
        send_edit(OP_LEFT, 8'h00, 13'd4096);
        send_edit(OP_RIGHT, 8'h00, 13'd1);
        send_edit(OP_RIGHT, 8'h00, 13'd0);
        send_edit(OP_DELETE, 8'h00, 13'd0);
        send_edit(OP_RIGHT, 8'h00, 13'd4096);
        for (int i = 0; i < 8; i++)
            send_edit(OP_INSERT, 8'h30 + SYM_W'(i), 13'd0);
        send_edit(OP_LEFT, 8'h00, 13'd12);

        // Narrowing the width leaves the column beyond the last one.
        send_edit(OP_RIGHT, 8'h00, 13'd4096);
        set_width(8'd3);
        send_edit(OP_INSERT, 8'h5A, 13'd0);
        send_edit(OP_DELETE, 8'h00, 13'd0);
        send_edit(OP_LEFT, 8'h00, 13'd5);

        hold_req = 1'b1;
        random_edits(90);
        set_width(8'd1);
        random_edits(70);
        set_width(8'd255);
        random_edits(70);
        set_width(8'd0);
        random_edits(70);
        set_width(COL_W'($urandom_range(2, 254)));
        random_edits(70);

        // Work across both ends of the text, then delete back toward the start.
        set_width(RESET_WIDTH);
        drain();
        send_edit(OP_INSERT, 8'h55, 13'd0);
        send_edit(OP_LEFT, 8'h00, 13'd4096);
        send_edit(OP_DELETE, 8'h00, 13'd0);
        send_edit(OP_INSERT, 8'h55, 13'd0);
        send_edit(OP_RIGHT, 8'h00, 13'd4096);
        for (int i = 0; i < 30; i++)
            send_edit(OP_DELETE, 8'h00, 13'd0);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
